@@ src/qat_pkg.sv @@
// Shared types, constants and helpers for the quoted argument tokenizer.
// No dependencies; imported by every module of the block.
package qat_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_END_ARG = 2'd1,
        KIND_END_MSG = 2'd2
    } qat_kind_t;

    typedef struct packed {
        qat_kind_t  kind;
        logic [7:0] ch;
    } qat_result_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        qat_result_t [MaxResults-1:0] res;
    } qat_bundle_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

@@ src/quoted_argument_tokenizer.sv @@
// Top level of the quoted argument tokenizer: input register, parser and result register.
// Depends on qat_pkg, qat_parse and qat_out_buf.
//
// Usage:
//   Slave channel: one message byte per beat on s_axis_tdata, s_axis_tlast on the
//   final byte of the message. Master channel: one token beat each, tuser gives the
//   kind (argument byte, end of argument, end of message), tdata the byte for argument
//   bytes and zero otherwise, tlast marks the last beat caused by one input byte.
//   A byte may cause no beat at all (skipped whitespace, opening quote, backslash).
//   Each accepted byte is written into the input register, and moves on into the result
//   register once that register is free; its first beat is offered from there.
//   Throughput: one input byte per cycle while each byte yields at most one beat and
//   m_axis_tready is high; a byte with more beats holds the result register until the
//   master side, one beat per cycle, has sent them all. At most four beats come from one byte.
//   Reset (aresetn low, synchronous) empties both registers and returns the parser
//   to the between-arguments state at the start of a message.
//   When the receiver stalls, the result register holds its beats, the input
//   register takes one more byte and then s_axis_tready drops until beats drain.
module quoted_argument_tokenizer
    import qat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // msg_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // run_last
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        free;
    logic        load;
    qat_bundle_t bundle;

    assign load          = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    qat_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (load),
        .in_char (in_char_reg),
        .in_last (in_last_reg),
        .bundle  (bundle)
    );

    qat_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .bundle        (bundle),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !free |=> in_valid_reg && $stable(in_char_reg))
        else $error("held input byte lost while result register busy");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_kind_char_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != KIND_CHAR |-> m_axis_tdata == 8'h00)
        else $error("nonzero data on a mark beat");

endmodule

@@ src/qat_parse.sv @@
// Parser state and the per-byte decode into up to four result beats.
// Depends on qat_pkg.
module qat_parse
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output qat_bundle_t bundle
);

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_PLAIN   = 2'd1,
        MODE_SQUOTE  = 2'd2,
        MODE_DQUOTE  = 2'd3
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  escape_reg, escape_next;
    logic  nonempty_reg, nonempty_next;
    logic  started_reg, started_next;

    logic [CountW-1:0] n;
    logic [7:0]        quote;

    always_comb begin
        mode_next     = mode_reg;
        escape_next   = escape_reg;
        nonempty_next = nonempty_reg;
        started_next  = started_reg;
        n             = '0;
        bundle.res    = '0;
        quote         = (mode_reg == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;

        case (mode_reg)
            MODE_BETWEEN: begin
                if (!(in_char == CH_SPACE || (!started_reg && is_ws(in_char)))) begin
                    started_next  = 1'b1;
                    nonempty_next = 1'b0;
                    escape_next   = 1'b0;
                    if (in_char == CH_DQUOTE) begin
                        mode_next = MODE_DQUOTE;
                    end else if (in_char == CH_SQUOTE) begin
                        mode_next = MODE_SQUOTE;
                    end else begin
                        bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, in_char};
                        n             = n + 1'b1;
                        mode_next     = MODE_PLAIN;
                        nonempty_next = 1'b1;
                    end
                end
            end
            MODE_PLAIN: begin
                if (in_char == CH_SPACE) begin
                    bundle.res[n[IdxW-1:0]] = '{KIND_END_ARG, 8'h00};
                    n             = n + 1'b1;
                    mode_next     = MODE_BETWEEN;
                    nonempty_next = 1'b0;
                end else begin
                    bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, in_char};
                    n             = n + 1'b1;
                    nonempty_next = 1'b1;
                end
            end
            default: begin
                if (escape_reg) begin
                    escape_next = 1'b0;
                    // unescapable byte keeps its backslash
                    if (!(in_char == quote || in_char == CH_BSLASH)) begin
                        bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, CH_BSLASH};
                        n = n + 1'b1;
                    end
                    bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, in_char};
                    n             = n + 1'b1;
                    nonempty_next = 1'b1;
                end else if (in_char == CH_BSLASH) begin
                    if (in_last) begin
                        bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, in_char};
                        n             = n + 1'b1;
                        nonempty_next = 1'b1;
                    end else begin
                        escape_next = 1'b1;
                    end
                end else if (in_char == quote) begin
                    bundle.res[n[IdxW-1:0]] = '{KIND_END_ARG, 8'h00};
                    n             = n + 1'b1;
                    mode_next     = MODE_BETWEEN;
                    nonempty_next = 1'b0;
                end else begin
                    bundle.res[n[IdxW-1:0]] = '{KIND_CHAR, in_char};
                    n             = n + 1'b1;
                    nonempty_next = 1'b1;
                end
            end
        endcase

        if (in_last) begin
            if (mode_next != MODE_BETWEEN && nonempty_next) begin
                bundle.res[n[IdxW-1:0]] = '{KIND_END_ARG, 8'h00};
                n = n + 1'b1;
            end
            bundle.res[n[IdxW-1:0]] = '{KIND_END_MSG, 8'h00};
            n             = n + 1'b1;
            mode_next     = MODE_BETWEEN;
            escape_next   = 1'b0;
            nonempty_next = 1'b0;
            started_next  = 1'b0;
        end

        bundle.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_BETWEEN;
            escape_reg   <= 1'b0;
            nonempty_reg <= 1'b0;
            started_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            escape_reg   <= escape_next;
            nonempty_reg <= nonempty_next;
            started_reg  <= started_next;
        end
    end

    a_escape_in_quotes: assert property (@(posedge aclk) disable iff (!aresetn)
        escape_reg |-> (mode_reg == MODE_SQUOTE || mode_reg == MODE_DQUOTE))
        else $error("escape pending outside a quoted argument");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last |=> mode_reg == MODE_BETWEEN && !started_reg && !escape_reg)
        else $error("parser state not cleared after end of message");

    a_last_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        in_last |-> bundle.count != '0
                    && bundle.res[bundle.count[IdxW-1:0] - 1'b1].kind == KIND_END_MSG)
        else $error("final byte without end-of-message beat");

    a_plain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_PLAIN |-> nonempty_reg)
        else $error("plain argument open without a byte");

endmodule

@@ src/qat_out_buf.sv @@
// Result register: holds the beats of one decoded byte and sends them one per cycle
// while m_axis_tready is high. Depends on qat_pkg.
module qat_out_buf
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  qat_bundle_t bundle,
    output logic        free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // run_last
);

    qat_result_t [MaxResults-1:0] res_reg;
    logic [CountW-1:0] cnt_reg;
    logic [IdxW-1:0]   idx_reg;
    logic              at_end;
    logic              take;

    assign at_end        = ({1'b0, idx_reg} == cnt_reg - 1'b1);
    assign m_axis_tvalid = (cnt_reg != '0);
    assign take          = m_axis_tvalid && m_axis_tready;
    assign free          = !m_axis_tvalid || (take && at_end);
    assign m_axis_tdata  = res_reg[idx_reg].ch;
    assign m_axis_tuser  = res_reg[idx_reg].kind;
    assign m_axis_tlast  = at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= bundle.count;
            idx_reg <= '0;
        end else if (take) begin
            if (at_end) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= bundle.res;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CountW'(MaxResults))
        else $error("result count out of range");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("result register overwritten before drained");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        take && at_end && !load |=> !m_axis_tvalid)
        else $error("beats left after the last one was taken");

endmodule

@@ tb/qat_token_checker.sv @@
// Scoreboard for the quoted argument tokenizer. It predicts the token beats that
// each accepted message byte causes and compares them with the master channel.
// Depends on qat_pkg for the token kinds and character codes.
module qat_token_checker
    import qat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_char
    input  logic       s_tlast,     // msg_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,     // [7:0] out_char
    input  logic [1:0] m_tuser,     // [1:0] kind
    input  logic       m_tlast,     // run_last
    output int         fail_count,
    output int         tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_PLAIN   = 2'd1,
        MODE_SQUOTE  = 2'd2,
        MODE_DQUOTE  = 2'd3
    } parse_mode_e;

    typedef struct packed {
        qat_kind_t  kind;
        logic [7:0] ch;
        logic       run_last;
    } token_t;

    parse_mode_e mode;
    logic        escaping;
    logic        arg_has_bytes;
    logic        text_seen;
    token_t      expected_tokens[$];

    function automatic token_t make_token(input qat_kind_t kind, input logic [7:0] ch);
        token_t t;
        t.kind     = kind;
        t.ch       = ch;
        t.run_last = 1'b0;
        return t;
    endfunction

    function automatic void clear_parser();
        mode          = MODE_BETWEEN;
        escaping      = 1'b0;
        arg_has_bytes = 1'b0;
        text_seen     = 1'b0;
    endfunction

    // Advance the parser by one message byte and queue the beats it causes.
    function automatic void tokenize_byte(input logic [7:0] c, input logic last);
        token_t     run[$];
        logic [7:0] closer;
        logic       blank;
        blank  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        closer = (mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        case (mode)
            MODE_BETWEEN: begin
                // only a space separates once text has started
                if (c != CH_SPACE && !(blank && !text_seen)) begin
                    text_seen     = 1'b1;
                    arg_has_bytes = 1'b0;
                    escaping      = 1'b0;
                    if (c == CH_DQUOTE) begin
                        mode = MODE_DQUOTE;
                    end else if (c == CH_SQUOTE) begin
                        mode = MODE_SQUOTE;
                    end else begin
                        run.push_back(make_token(KIND_CHAR, c));
                        mode          = MODE_PLAIN;
                        arg_has_bytes = 1'b1;
                    end
                end
            end
            MODE_PLAIN: begin
                if (c == CH_SPACE) begin
                    run.push_back(make_token(KIND_END_ARG, 8'h00));
                    mode          = MODE_BETWEEN;
                    arg_has_bytes = 1'b0;
                end else begin
                    run.push_back(make_token(KIND_CHAR, c));
                    arg_has_bytes = 1'b1;
                end
            end
            default: begin
                if (escaping) begin
                    escaping = 1'b0;
                    // keep the backslash when it escapes nothing
                    if (c != closer && c != CH_BSLASH) begin
                        run.push_back(make_token(KIND_CHAR, CH_BSLASH));
                    end
                    run.push_back(make_token(KIND_CHAR, c));
                    arg_has_bytes = 1'b1;
                end else if (c == CH_BSLASH && !last) begin
                    escaping = 1'b1;
                end else if (c == closer) begin
                    run.push_back(make_token(KIND_END_ARG, 8'h00));
                    mode          = MODE_BETWEEN;
                    arg_has_bytes = 1'b0;
                end else begin
                    run.push_back(make_token(KIND_CHAR, c));
                    arg_has_bytes = 1'b1;
                end
            end
        endcase
        if (last) begin
            if (mode != MODE_BETWEEN && arg_has_bytes) begin
                run.push_back(make_token(KIND_END_ARG, 8'h00));
            end
            run.push_back(make_token(KIND_END_MSG, 8'h00));
            clear_parser();
        end
        if (run.size() > 0) begin
            run[run.size() - 1].run_last = 1'b1;
        end
        foreach (run[i]) begin
            expected_tokens.push_back(run[i]);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        token_t want;
        if (!aresetn) begin
            clear_parser();
            expected_tokens.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                tokenize_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected beat: kind %0d, char 0x%02h, last %0b",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected 0x%02h, got 0x%02h", want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        tokens_pending = expected_tokens.size();
    end

endmodule

@@ tb/quoted_argument_tokenizer_tb.sv @@
// Top of the quoted argument tokenizer testbench: clock, reset, message stimulus
// and receiver back-pressure. Depends on qat_pkg, quoted_argument_tokenizer and
// qat_token_checker, which does all prediction and comparison.
module quoted_argument_tokenizer_tb;
    import qat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytes = 430;
    localparam int HoldOffCycles = 400;
    localparam int CycleLimit = 400000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    int         fail_count;
    int         tokens_pending;
    int         bytes_sent;
    int         beats_taken;
    int         cycle_count;
    logic       tx_calm;
    logic       rx_calm;
    logic [7:0] msg_bytes[$];

    quoted_argument_tokenizer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    qat_token_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tlast        (s_axis_tlast),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending)
    );

    always #5 aclk = ~aclk;

    // Bias toward the bytes the parser treats specially.
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_DQUOTE;
            2: return CH_SQUOTE;
            3: return CH_BSLASH;
            4: return 8'($urandom_range(9, 13));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one byte after a random gap; return at the edge that accepts it.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_msg();
        tx_calm = ($urandom_range(0, 3) == 0);
        foreach (msg_bytes[i]) begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
    endtask

    initial begin : cycle_watchdog
        for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) begin
            @(posedge aclk);
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : receiver
        int gap;
        beats_taken = 0;
        rx_calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                rx_calm = !rx_calm;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            // hold off long enough for the block to back up into its input
            if (beats_taken % 500 == 60) begin
                gap = HoldOffCycles;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            beats_taken++;
        end
    end

    initial begin : stimulus
        int nargs;
        int len;
        int style;
        logic [7:0] quote;
        logic [7:0] b;
        bytes_sent = 0;
        tx_calm = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leading whitespace, empty closed quote, plain word ending the message
        msg_bytes = '{CH_SPACE, CH_TAB, CH_CR, CH_SQUOTE, CH_SQUOTE, CH_SPACE, 8'h78};
        send_msg();
        // escaped quote, unescapable byte, word right after a closing quote, trailing tab
        msg_bytes = '{CH_DQUOTE, 8'h61, CH_BSLASH, CH_DQUOTE, CH_BSLASH, 8'h71,
                      CH_DQUOTE, 8'h62, CH_TAB};
        send_msg();
        // escaped backslash, then a backslash as the final byte
        msg_bytes = '{CH_SQUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH};
        send_msg();
        // pending escape resolved by the final byte: four beats from one byte
        msg_bytes = '{CH_SQUOTE, CH_BSLASH, 8'hFF};
        send_msg();
        // tab between arguments starts a new one
        msg_bytes = '{8'h00, CH_SPACE, CH_TAB};
        send_msg();
        // unterminated empty quote
        msg_bytes = '{CH_DQUOTE};
        send_msg();

        bytes_sent = 0;
        while (bytes_sent < RandomBytes) begin
            msg_bytes.delete();
            if ($urandom_range(0, 5) == 0) begin
                // noise
                repeat ($urandom_range(1, 12)) msg_bytes.push_back(any_byte());
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    msg_bytes.push_back($urandom_range(0, 1) ? CH_SPACE
                                                              : 8'($urandom_range(9, 13)));
                end
                nargs = $urandom_range(1, 4);
                for (int a = 0; a < nargs; a++) begin
                    if (a > 0) begin
                        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2)) begin
                            msg_bytes.push_back(CH_SPACE);
                        end
                    end
                    style = $urandom_range(0, 2);
                    len = $urandom_range(0, 5);
                    if (style == 0) begin
                        for (int i = 0; i < len + 1; i++) begin
                            b = any_byte();
                            if (b == CH_SPACE || (i == 0 && (b == CH_SQUOTE || b == CH_DQUOTE))) begin
                                b = 8'h78;
                            end
                            msg_bytes.push_back(b);
                        end
                    end else begin
                        quote = (style == 1) ? CH_SQUOTE : CH_DQUOTE;
                        msg_bytes.push_back(quote);
                        repeat (len) begin
                            if ($urandom_range(0, 5) == 0) begin
                                msg_bytes.push_back(CH_BSLASH);
                                case ($urandom_range(0, 2))
                                    0: msg_bytes.push_back(quote);
                                    1: msg_bytes.push_back(CH_BSLASH);
                                    default: msg_bytes.push_back(any_byte());
                                endcase
                            end else begin
                                b = any_byte();
                                if (b == quote || b == CH_BSLASH) begin
                                    msg_bytes.push_back(CH_BSLASH);
                                end
                                msg_bytes.push_back(b);
                            end
                        end
                        // leave the last argument open now and then
                        if (!(a == nargs - 1 && $urandom_range(0, 4) == 0)) begin
                            msg_bytes.push_back(quote);
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) msg_bytes.push_back(CH_SPACE);
                end
            end
            send_msg();
        end
        s_axis_tvalid <= 1'b0;

        // let the checker queue the beats of the final byte before polling
        @(posedge aclk);
        while (tokens_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
